FILE: hw/rtl/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants for the vector normaliser
// Pipeline word types for the square-root and divider cell rows.
// ----------------------------------------------------------------------------
package v3n_pkg;

	localparam int unsigned CompW  = 32;
	localparam int unsigned MagW   = 32;
	localparam int unsigned SumW   = 64;
	localparam int unsigned UnitSh = 30;
	localparam int unsigned DivW   = CompW + UnitSh;  // abs(component) << 30
	localparam int unsigned NumW   = 3;

	// Square-root cell payload
	typedef struct packed {
		logic [SumW-1:0]  rad;   // radicand, shifted left two bits per cell
		logic [MagW+1:0]  rem;   // partial remainder
		logic [MagW-1:0]  root;  // partial root
	} sqrt_word_t;

	// Divider cell payload, one per component
	typedef struct packed {
		logic [DivW-1:0]  num;   // dividend bits still to enter
		logic [MagW:0]    rem;   // partial remainder
		logic [DivW-1:0]  quo;   // quotient so far
		logic             neg;   // component sign
	} div_word_t;

	// Side data carried alongside the cells
	typedef struct packed {
		logic [CompW-1:0] ax;
		logic [CompW-1:0] ay;
		logic [CompW-1:0] az;
		logic             nx;
		logic             ny;
		logic             nz;
	} side_t;

endpackage

FILE: hw/rtl/v3n_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v3n_sqrt_cell: one root bit of the restoring square root
// Takes two radicand bits, trial-subtracts and registers the result.
// ----------------------------------------------------------------------------
module v3n_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  v3n_pkg::sqrt_word_t d_in,
	input  v3n_pkg::side_t     side_in,
	output logic               vld_out,
	output v3n_pkg::sqrt_word_t d_out,
	output v3n_pkg::side_t     side_out
);

	logic [v3n_pkg::MagW+1:0] shifted;
	logic [v3n_pkg::MagW+1:0] trial;
	v3n_pkg::sqrt_word_t      nxt;

	always_comb begin
		shifted = {d_in.rem[v3n_pkg::MagW-1:0],
			d_in.rad[v3n_pkg::SumW-1 -: 2]};
		trial   = {d_in.root, 2'b01};
		nxt.rad = {d_in.rad[v3n_pkg::SumW-3:0], 2'b00};
		if (shifted >= trial) begin
			nxt.rem  = shifted - trial;
			nxt.root = {d_in.root[v3n_pkg::MagW-2:0], 1'b1};
		end else begin
			nxt.rem  = shifted;
			nxt.root = {d_in.root[v3n_pkg::MagW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		d_out    <= nxt;
		side_out <= side_in;
	end

endmodule

FILE: hw/rtl/v3n_div_cell.sv
// ----------------------------------------------------------------------------
// v3n_div_cell: one quotient bit of three restoring dividers
// All three components share the divisor carried alongside.
// ----------------------------------------------------------------------------
module v3n_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_in,
	input  logic [v3n_pkg::MagW-1:0]    mag_in,
	input  v3n_pkg::div_word_t          d_in  [v3n_pkg::NumW],
	output logic                        vld_out,
	output logic [v3n_pkg::MagW-1:0]    mag_out,
	output v3n_pkg::div_word_t          d_out [v3n_pkg::NumW]
);

	v3n_pkg::div_word_t     nxt [v3n_pkg::NumW];
	logic [v3n_pkg::MagW:0] sh  [v3n_pkg::NumW];

	always_comb begin
		for (int i = 0; i < v3n_pkg::NumW; i++) begin
			sh[i]      = {d_in[i].rem[v3n_pkg::MagW-1:0], d_in[i].num[v3n_pkg::DivW-1]};
			nxt[i].num = {d_in[i].num[v3n_pkg::DivW-2:0], 1'b0};
			nxt[i].neg = d_in[i].neg;
			if (sh[i] >= {1'b0, mag_in}) begin
				nxt[i].rem = sh[i] - {1'b0, mag_in};
				nxt[i].quo = {d_in[i].quo[v3n_pkg::DivW-2:0], 1'b1};
			end else begin
				nxt[i].rem = sh[i];
				nxt[i].quo = {d_in[i].quo[v3n_pkg::DivW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		mag_out <= mag_in;
		d_out   <= nxt;
	end

endmodule

FILE: hw/rtl/vector3_normalize_top.sv
// ----------------------------------------------------------------------------
// vector3_normalize_top: length and unit vector of a Q16.16 3-vector
// Abs, squares, 32-cell root row, 62-cell divider row, output register.
// ----------------------------------------------------------------------------
// A request passes stages 1 and 2, both cell rows and the output register.
// Throughput: one request per cycle; busy is never raised.
// The rate is set by the cell rows, each cell one root or quotient bit.
// Reset clears the valid chain and done; payload and unit_valid are not reset.
// The receiver cannot stall: each result is strobed for one cycle only.
module vector3_normalize_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic        done,
	output logic signed [31:0] unit_x,
	output logic signed [31:0] unit_y,
	output logic signed [31:0] unit_z,
	output logic [31:0] magnitude,
	output logic        unit_valid
);

	localparam int unsigned SqN  = v3n_pkg::MagW;
	localparam int unsigned DvN  = v3n_pkg::DivW;
	localparam int unsigned SqrW = 2 * v3n_pkg::CompW;

	assign busy = 1'b0;

	// stage 1: absolute values
	logic              vld_s1;
	v3n_pkg::side_t    side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.ax <= vec_x[31] ? 32'(-vec_x) : vec_x;
		side_s1.ay <= vec_y[31] ? 32'(-vec_y) : vec_y;
		side_s1.az <= vec_z[31] ? 32'(-vec_z) : vec_z;
		side_s1.nx <= vec_x[31];
		side_s1.ny <= vec_y[31];
		side_s1.nz <= vec_z[31];
	end

	// stage 2: squares; their sum feeds the root row
	logic              vld_s2;
	v3n_pkg::side_t    side_s2;
	logic [SqrW-1:0]   sx_s2, sy_s2, sz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		sx_s2   <= side_s1.ax * side_s1.ax;
		sy_s2   <= side_s1.ay * side_s1.ay;
		sz_s2   <= side_s1.az * side_s1.az;
	end

	// root row
	logic                 sq_vld  [SqN+1];
	v3n_pkg::sqrt_word_t  sq_d    [SqN+1];
	v3n_pkg::side_t       sq_side [SqN+1];

	assign sq_vld[0]      = vld_s2;
	assign sq_d[0].rad    = sx_s2 + sy_s2 + sz_s2;
	assign sq_d[0].rem    = '0;
	assign sq_d[0].root   = '0;
	assign sq_side[0]     = side_s2;

	for (genvar g = 0; g < SqN; g++) begin : g_sqrt
		v3n_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (sq_vld[g]),
			.d_in     (sq_d[g]),
			.side_in  (sq_side[g]),
			.vld_out  (sq_vld[g+1]),
			.d_out    (sq_d[g+1]),
			.side_out (sq_side[g+1])
		);
	end

	// divider row
	logic                     dv_vld [DvN+1];
	logic [v3n_pkg::MagW-1:0] dv_mag [DvN+1];
	v3n_pkg::div_word_t       dv_d   [DvN+1][v3n_pkg::NumW];

	assign dv_vld[0] = sq_vld[SqN];
	assign dv_mag[0] = sq_d[SqN].root;
	always_comb begin
		dv_d[0][0].num = {sq_side[SqN].ax, {v3n_pkg::UnitSh{1'b0}}};
		dv_d[0][1].num = {sq_side[SqN].ay, {v3n_pkg::UnitSh{1'b0}}};
		dv_d[0][2].num = {sq_side[SqN].az, {v3n_pkg::UnitSh{1'b0}}};
		dv_d[0][0].neg = sq_side[SqN].nx;
		dv_d[0][1].neg = sq_side[SqN].ny;
		dv_d[0][2].neg = sq_side[SqN].nz;
		for (int i = 0; i < v3n_pkg::NumW; i++) begin
			dv_d[0][i].rem = '0;
			dv_d[0][i].quo = '0;
		end
	end

	for (genvar g = 0; g < DvN; g++) begin : g_div
		v3n_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (dv_vld[g]),
			.mag_in  (dv_mag[g]),
			.d_in    (dv_d[g]),
			.vld_out (dv_vld[g+1]),
			.mag_out (dv_mag[g+1]),
			.d_out   (dv_d[g+1])
		);
	end

	// output register; sign applied and zero length forced here
	logic        nz_len;
	logic [31:0] q [v3n_pkg::NumW];

	assign nz_len = (dv_mag[DvN] != '0);
	always_comb begin
		for (int i = 0; i < v3n_pkg::NumW; i++) begin
			q[i] = dv_d[DvN][i].quo[31:0];
			if (dv_d[DvN][i].neg) begin
				q[i] = 32'(-q[i]);
			end
			if (!nz_len) begin
				q[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld[DvN];
		end
	end

	always_ff @(posedge clk) begin
		unit_x     <= q[0];
		unit_y     <= q[1];
		unit_z     <= q[2];
		magnitude  <= dv_mag[DvN];
		unit_valid <= nz_len;
	end

endmodule

FILE: tb/tb_norm_checker.sv
// ----------------------------------------------------------------------------
// tb_norm_checker: scoreboard for the vector normaliser
// Watches accepted requests and result strobes, predicts length and unit
// vector for each request and compares results in order.
// ----------------------------------------------------------------------------
module tb_norm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic               done,
	input  logic signed [31:0] unit_x,
	input  logic signed [31:0] unit_y,
	input  logic signed [31:0] unit_z,
	input  logic [31:0]        magnitude,
	input  logic               unit_valid,
	output int                 errors,
	output int                 pending,
	output int                 n_results,
	output int                 n_null
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] ux;
		logic [31:0] uy;
		logic [31:0] uz;
		logic [31:0] mag;
		logic        ok;
	} norm_res_t;

	norm_res_t expected_q[$];

	function automatic logic [63:0] abs_comp(logic [31:0] c);
		return c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] b;
		rem = v;
		root = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] scale_comp(logic [31:0] c, logic [63:0] m);
		logic [63:0] q;
		q = (abs_comp(c) << 30) / m;
		if (c[31])
			q = -q;
		return q[31:0];
	endfunction

	function automatic norm_res_t normalise(logic [31:0] x, logic [31:0] y,
	                                       logic [31:0] z);
		norm_res_t r;
		logic [63:0] ax, ay, az, m;
		ax = abs_comp(x);
		ay = abs_comp(y);
		az = abs_comp(z);
		m = floor_sqrt(ax * ax + ay * ay + az * az);
		r = '0;
		if (m != 0) begin
			r.ux = scale_comp(x, m);
			r.uy = scale_comp(y, m);
			r.uz = scale_comp(z, m);
			r.mag = m[31:0];
			r.ok = 1'b1;
		end
		return r;
	endfunction

	initial begin
		errors = 0;
		n_results = 0;
		n_null = 0;
	end

	assign pending = expected_q.size();

	always @(posedge clk) begin
		norm_res_t e;
		if (arst_n) begin
			if (start && !busy)
				expected_q.push_back(normalise(vec_x, vec_y, vec_z));
			if (done) begin
				n_results <= n_results + 1;
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding");
					errors = errors + 1;
				end else begin
					e = expected_q.pop_front();
					if (!e.ok)
						n_null <= n_null + 1;
					if (unit_x !== e.ux) begin
						$error("unit_x exp %h got %h", e.ux, unit_x);
						errors = errors + 1;
					end
					if (unit_y !== e.uy) begin
						$error("unit_y exp %h got %h", e.uy, unit_y);
						errors = errors + 1;
					end
					if (unit_z !== e.uz) begin
						$error("unit_z exp %h got %h", e.uz, unit_z);
						errors = errors + 1;
					end
					if (magnitude !== e.mag) begin
						$error("magnitude exp %h got %h", e.mag, magnitude);
						errors = errors + 1;
					end
					if (unit_valid !== e.ok) begin
						$error("unit_valid exp %b got %b", e.ok, unit_valid);
						errors = errors + 1;
					end
				end
			end
		end
	end
endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the vector normaliser
// Directed corner vectors then bursty random requests; results are checked
// by tb_norm_checker.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 97;
	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] vec_x, vec_y, vec_z;
	logic done;
	logic signed [31:0] unit_x, unit_y, unit_z;
	logic [31:0] magnitude;
	logic unit_valid;
	int errors, pending, n_results, n_null;
	int n_req;
	int idle_cycles;

	vector3_normalize_top dut (.*);

	tb_norm_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles with nothing accepted or returned
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout waiting for results");
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			1: return $urandom_range(0, 3) - 2;
			2: return $signed($urandom_range(0, 65535)) - 32768;
			3: return 32'($signed($urandom_range(0, 2 ** 24))) - (1 << 23);
			default: return $urandom();
		endcase
	endfunction

	// one request; holds start high across back-to-back requests
	task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z,
	                    bit keep);
		start <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		do @(posedge clk); while (busy);
		n_req++;
		if (!keep)
			start <= 1'b0;
	endtask

	initial begin
		logic [31:0] corners [10];
		int burst;
		idle_cycles = 0;
		n_req = 0;
		arst_n = 1'b0;
		start = 1'b0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		corners = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
		            32'h0001_0000, 32'hffff_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h2};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// zero vector, single-axis corners, most negative values, mixed
		send(0, 0, 0, 1);
		foreach (corners[i])
			send(corners[i], 0, 0, 1);
		send(0, 32'h8000_0000, 0, 1);
		send(0, 0, 32'h8000_0000, 1);
		send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
		send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
		send(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1);
		send(1, 1, 1, 1);
		send(32'hffff_ffff, 1, 32'hffff_ffff, 1);
		send(32'h0003_0000, 32'h0004_0000, 0, 0);
		send(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 0);
		while (n_req < 720) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) begin
				if ($urandom_range(0, 19) == 0)
					send(0, 0, 0, k < burst - 1);
				else
					send(rand_comp(), rand_comp(), rand_comp(), k < burst - 1);
			end
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15)) @(posedge clk);
		end
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("%0d requests sent, %0d results checked (%0d zero-length)",
		         n_req, n_results, n_null);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/v3n_pkg.sv
hw/rtl/v3n_sqrt_cell.sv
hw/rtl/v3n_div_cell.sv
hw/rtl/vector3_normalize_top.sv
tb/tb_norm_checker.sv
tb/tb_top.sv
